### hw/rtl/trismo_pkg.sv
// Package for the triangular window smoother.
// Sizing constants and the beat types of the input and output channels.
// No dependencies.
package trismo_pkg;

  localparam int MAX_HALF    = 15;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 4;
  localparam int HALF_RESET  = 1;
  localparam int HALF_W      = $clog2(MAX_HALF + 1);
  localparam int LINE_DEPTH  = 2 * MAX_HALF + 1;
  localparam int LINE_W      = $clog2(LINE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int COUNT_MAX   = 31;
  localparam int TOT_W       = $clog2((MAX_HALF + 1) * (MAX_HALF + 1) + 1);
  localparam int ACC_W       = SAMPLE_BITS + TOT_W;
  localparam int DIV_W       = $clog2(ACC_W);
  localparam int EMIT_W      = HALF_W + 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } sample_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          last_result;
  } result_beat_t;

endpackage

### hw/rtl/triangular_window_smoother.sv
// Top level of the triangular window smoother.
// Depends on trismo_pkg for constants and beat types.
// Steps per sample: MAC over the 2h+1 taps, absolute value, bit-serial divide over ACC_W (25)
// quotient bits, sign restore, then emit of its result beats, each held while the output stalls.
// A last sample also emits the extra beats that flush the window.
// A sample that yields no result and needs no mean is taken without leaving idle. One shared MAC and a
// bit-serial restoring divider do the work; one sample is in work at a time.
// Reset: asynchronous active low; half width returns to 1, position count to 0.
module triangular_window_smoother
  import trismo_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  sample_beat_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output result_beat_t out_data_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_ABS, ST_DIV, ST_FIN, ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    half_width_q;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  logic [EMIT_W-1:0]   emit_left_q, emit_left_d;
  logic [DIV_W-1:0]    div_cnt_q, div_cnt_d;
  logic [LINE_W-1:0]   k_q, k_d;

  logic signed [SAMPLE_BITS-1:0] delay_q [LINE_DEPTH];
  logic [HALF_W-1:0]   h_q, h_d;
  logic                last_q, last_d;
  logic                first_q, first_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0]    mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [TOT_W-1:0]    rem_q, rem_d;
  logic [TOT_W-1:0]    total_q, total_d;
  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  result_beat_t        out_q, out_d;

  logic                in_fire;
  logic [HALF_W-1:0]   h_eff;
  logic [EMIT_W-1:0]   h_plus1;
  logic [CNT_W:0]      i_ext;
  logic                i_ge_h, i_ge_2h;
  logic [EMIT_W-1:0]   emit_cnt;
  logic [LINE_W:0]     tap_gap;
  logic [EMIT_W-1:0]   weight;
  logic signed [SAMPLE_BITS+EMIT_W:0] prod;
  logic [TOT_W:0]      rem_sh;
  logic                rem_ge;
  logic [ACC_W-1:0]    neg_mag;
  logic                out_free;

  function automatic logic [EMIT_W-1:0] h_plus1_q();
    return EMIT_W'(h_q) + EMIT_W'(1);
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;

  assign h_eff   = (int'(half_width_q) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(half_width_q);
  assign h_plus1 = EMIT_W'(h_eff) + EMIT_W'(1);
  assign i_ext   = (CNT_W+1)'(pos_q);
  assign i_ge_h  = i_ext >= (CNT_W+1)'(h_eff);
  assign i_ge_2h = i_ext >= ((CNT_W+1)'(h_eff) << 1);

  always_comb begin
    if (in_data_i.last_sample) begin
      emit_cnt = i_ge_h ? h_plus1 : EMIT_W'(i_ext + 1'b1);
    end else begin
      emit_cnt = i_ge_h ? EMIT_W'(1) : EMIT_W'(0);
    end
  end

  // triangular weight of tap k
  always_comb begin
    if ((LINE_W+1)'(k_q) > (LINE_W+1)'(h_q)) begin
      tap_gap = (LINE_W+1)'(k_q) - (LINE_W+1)'(h_q);
    end else begin
      tap_gap = (LINE_W+1)'(h_q) - (LINE_W+1)'(k_q);
    end
    weight = EMIT_W'((LINE_W+1)'(h_q) + 1'b1 - tap_gap);
    prod   = delay_q[k_q] * $signed({1'b0, weight});
  end

  assign rem_sh  = {rem_q, mag_q[ACC_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, total_q};
  assign neg_mag = ACC_W'(0) - mag_q;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    emit_left_d = emit_left_q;
    div_cnt_d   = div_cnt_q;
    k_d         = k_q;
    h_d         = h_q;
    last_d      = last_q;
    first_d     = first_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    total_d     = total_q;
    val_d       = val_q;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          h_d         = h_eff;
          last_d      = in_data_i.last_sample;
          first_d     = 1'b1;
          emit_left_d = emit_cnt;
          acc_d       = '0;
          k_d         = '0;
          val_d       = '0;
          if (in_data_i.last_sample) begin
            pos_d = '0;
          end else if (int'(pos_q) < COUNT_MAX) begin
            pos_d = pos_q + 1'b1;
          end
          if (i_ge_h && i_ge_2h) begin
            state_d = ST_MAC;
          end else if (emit_cnt != '0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_MAC: begin
        acc_d = acc_q + ACC_W'(prod);
        k_d   = k_q + 1'b1;
        if (k_q == LINE_W'({h_q, 1'b0})) begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        neg_d     = acc_q[ACC_W-1];
        mag_d     = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
        rem_d     = '0;
        total_d   = TOT_W'(h_plus1_q()) * TOT_W'(h_plus1_q());
        div_cnt_d = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        rem_d     = rem_ge ? TOT_W'(rem_sh - {1'b0, total_q}) : TOT_W'(rem_sh);
        mag_d     = {mag_q[ACC_W-2:0], rem_ge};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_W'(ACC_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        val_d   = neg_q ? SAMPLE_BITS'(neg_mag) : SAMPLE_BITS'(mag_q);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.smoothed    = first_q ? val_q : '0;
          out_d.last_result = last_q && (emit_left_q == EMIT_W'(1));
          first_d           = 1'b0;
          emit_left_d       = emit_left_q - 1'b1;
          if (emit_left_q == EMIT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      emit_left_q  <= '0;
      div_cnt_q    <= '0;
      k_q          <= '0;
      half_width_q <= CFG_W'(HALF_RESET);
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      emit_left_q <= emit_left_d;
      div_cnt_q   <= div_cnt_d;
      k_q         <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        half_width_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    last_q  <= last_d;
    first_q <= first_d;
    acc_q   <= acc_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    rem_q   <= rem_d;
    total_q <= total_d;
    val_q   <= val_d;
    out_q   <= out_d;
    if (in_fire) begin
      delay_q[0] <= in_data_i.sample;
      for (int j = 1; j < LINE_DEPTH; j++) begin
        delay_q[j] <= delay_q[j-1];
      end
    end
  end

endmodule

### tb/sv/trismo_result_check.sv
// Result checker for the triangular window smoother testbench.
// Watches the sample, result and config channels, predicts the smoothed beats and compares.
// Depends on trismo_pkg for sizing constants and beat types.
module trismo_result_check
  import trismo_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  sample_beat_t     in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  result_beat_t     out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               owed_count_o,
  output int               mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [SAMPLE_BITS-1:0] window_taps [LINE_DEPTH];
  logic [CNT_W-1:0]              taken;
  logic [CFG_W-1:0]              half_reg;
  result_beat_t                  owed_results[$];
  int                            mismatches;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int active_half();
    return (half_reg > MAX_HALF) ? MAX_HALF : int'(half_reg);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] window_mean(input int h);
    longint acc;
    longint total;
    int     gap;
    acc   = 0;
    total = longint'((h + 1) * (h + 1));
    for (int k = 0; k <= 2 * h; k++) begin
      gap = (k > h) ? k - h : h - k;
      acc += longint'(window_taps[k]) * longint'(h + 1 - gap);
    end
    // signed divide truncates toward zero
    return SAMPLE_BITS'(acc / total);
  endfunction

  task automatic advance_window(input sample_beat_t beat);
    int                            h;
    int                            i;
    int                            owed;
    logic signed [SAMPLE_BITS-1:0] first;
    result_beat_t                  r;
    h = active_half();
    i = int'(taken);
    for (int k = LINE_DEPTH - 1; k > 0; k--) window_taps[k] = window_taps[k-1];
    window_taps[0] = beat.sample;
    if (!beat.last_sample) begin
      if (i >= h) begin
        r.smoothed    = (i >= 2 * h) ? window_mean(h) : '0;
        r.last_result = 1'b0;
        owed_results.push_back(r);
      end
      if (taken != COUNT_MAX) taken = taken + 1'b1;
    end else begin
      owed  = (i + 1 < h + 1) ? i + 1 : h + 1;
      first = (i >= 2 * h) ? window_mean(h) : '0;
      for (int k = 0; k < owed; k++) begin
        r.smoothed    = (k == 0 && i >= h) ? first : '0;
        r.last_result = (k == owed - 1);
        owed_results.push_back(r);
      end
      taken = '0;
    end
  endtask

  task automatic check_result(input result_beat_t got);
    result_beat_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("unexpected beat smoothed=%0d last=%0b",
                                got.smoothed, got.last_result));
      return;
    end
    want = owed_results.pop_front();
    if (got.smoothed !== want.smoothed)
      report_mismatch($sformatf("smoothed got %0d want %0d", got.smoothed, want.smoothed));
    if (got.last_result !== want.last_result)
      report_mismatch($sformatf("last_result got %0b want %0b (smoothed %0d)",
                                got.last_result, want.last_result, want.smoothed));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LINE_DEPTH; k++) window_taps[k] = '0;
      taken      = '0;
      half_reg   = CFG_W'(HALF_RESET);
      mismatches = 0;
      owed_results.delete();
      owed_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (cfg_valid_i && cfg_ready_i) half_reg = cfg_data_i;
      if (in_valid_i && in_ready_i) advance_window(in_data_i);
      owed_count_o <= owed_results.size();
    end
  end

endmodule

### tb/sv/tb_triangular_window_smoother.sv
// Testbench top for the triangular window smoother: clock, reset, stimulus and verdict.
// Directed arrays first, then random arrays over several half widths with random idling.
// Depends on trismo_pkg, triangular_window_smoother and trismo_result_check.
module tb_triangular_window_smoother
  import trismo_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_CYCLES = 90;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT  = 300000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_NEG1 = '1;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ZERO = '0;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  sample_beat_t     in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  result_beat_t     out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  int owed_count;
  int mismatch_count;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  int cur_half  = HALF_RESET;

  triangular_window_smoother DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  trismo_result_check u_result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .owed_count_o     (owed_count),
    .mismatch_count_o (mismatch_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_ZERO;
      3: return SAMPLE_NEG1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_data_i.sample      <= s;
    in_data_i.last_sample <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // wait until every owed result has come out, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_half(input int h);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CFG_W'(h);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_half = h;
  endtask

  // random array; a nonzero split changes the half width partway through
  task automatic send_array(input int len, input int split);
    for (int k = 0; k < len; k++) begin
      if (split != 0 && k == split) begin
        settle();
        write_half($urandom_range(0, 15));
      end
      send_sample(pick_sample(), k == len - 1);
    end
  endtask

  initial begin : stimulus
    int sent;
    int phase;
    int arrays;
    int len;
    int split;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset half width of 1; small negative sums truncate toward zero
    send_sample(SAMPLE_NEG1, 1'b0);
    send_sample(SAMPLE_NEG1, 1'b0);
    send_sample(SAMPLE_ZERO, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_NEG1, 1'b1);
    settle();
    write_half(0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    settle();
    write_half(15);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    settle();
    write_half(2);
    for (int k = 0; k < 5; k++) send_sample(SAMPLE_MIN, k == 4);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    settle();
    write_half(3);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_NEG1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0:       write_half(0);
        1:       write_half(15);
        2:       write_half(1);
        default: write_half($urandom_range(0, 15));
      endcase
      calm   = (phase == 1 || phase == 4);
      arrays = $urandom_range(2, 5);
      for (int a = 0; a < arrays && sent < RANDOM_ITEMS; a++) begin
        if (phase == 0 && a == 0) begin
          hold_req = 1'b1;
          len      = 40;
        end else if ($urandom_range(0, 4) == 0) begin
          len = $urandom_range(32, 40);
        end else begin
          len = $urandom_range(1, 2 * cur_half + 6);
        end
        split = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : 0;
        send_array(len, split);
        sent += len;
      end
      phase++;
    end
    calm = 1'b0;

    settle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
